[hdl/dhfk_pkg.sv]
package dhfk_pkg;

    localparam int MAX_JOINTS = 8;
    localparam int CORDIC_N   = 30;

    // coefficient, angle-accumulator, product, sum and rounded widths
    localparam int CW = 34;
    localparam int ZW = 36;
    localparam int PW = 2 * CW;
    localparam int SW = 70;
    localparam int RW = SW - 30;

    localparam logic signed [ZW-1:0] PI_Q30     = 36'sd3373259426;
    localparam logic signed [ZW-1:0] HALFPI_Q30 = 36'sd1686629713;
    localparam logic signed [CW-1:0] CORDIC_K   = 34'sh026DD3B6A;
    localparam logic signed [31:0]   ONE_Q30    = 32'sh40000000;

    localparam logic CMD_GEOMETRY = 1'b0;
    localparam logic CMD_ANGLE    = 1'b1;

    localparam logic [3:0] STEP_BUILD0 = 4'd0;
    localparam logic [3:0] STEP_BUILD1 = 4'd1;
    localparam logic [3:0] STEP_BUBBLE = 4'd2;
    localparam logic [3:0] STEP_ELEM0  = 4'd3;
    localparam logic [3:0] STEP_LAST   = 4'd15;

    typedef struct packed {
        logic       start;
        logic       geo_write;
        logic       cordic_step;
        logic [4:0] iter;
        logic       mul_issue;
        logic [3:0] step;
        logic       commit;
        logic       load_out;
    } dhfk_cmd_t;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:    v = 36'sh03243F6A8;
            5'd1:    v = 36'sh01DAC6705;
            5'd2:    v = 36'sh00FADBAFC;
            5'd3:    v = 36'sh007F56EA6;
            5'd4:    v = 36'sh003FEAB76;
            5'd5:    v = 36'sh001FFD55B;
            5'd6:    v = 36'sh000FFFAAA;
            5'd7:    v = 36'sh0007FFF55;
            5'd8:    v = 36'sh0003FFFEA;
            5'd9:    v = 36'sh0001FFFFD;
            5'd10:   v = 36'sh0000FFFFF;
            5'd11:   v = 36'sh00007FFFF;
            5'd12:   v = 36'sh00003FFFF;
            5'd13:   v = 36'sh00001FFFF;
            5'd14:   v = 36'sh00000FFFF;
            5'd15:   v = 36'sh000007FFF;
            5'd16:   v = 36'sh000003FFF;
            5'd17:   v = 36'sh000001FFF;
            5'd18:   v = 36'sh000000FFF;
            5'd19:   v = 36'sh0000007FF;
            5'd20:   v = 36'sh0000003FF;
            5'd21:   v = 36'sh0000001FF;
            5'd22:   v = 36'sh0000000FF;
            5'd23:   v = 36'sh00000007F;
            5'd24:   v = 36'sh00000003F;
            5'd25:   v = 36'sh00000001F;
            5'd26:   v = 36'sh00000000F;
            5'd27:   v = 36'sh000000008;
            5'd28:   v = 36'sh000000004;
            5'd29:   v = 36'sh000000002;
            default: v = '0;
        endcase
        return v;
    endfunction

    // round a Q30-scaled product back: add half, floor shift by 30
    function automatic logic signed [RW-1:0] rnd30(input logic signed [SW-1:0] p);
        logic signed [SW-1:0] t;
        t = p + 70'sd536870912;
        return RW'(t >>> 30);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
        logic signed [31:0] r;
        if (v > 70'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -70'sd2147483648)
            r = 32'sh80000000;
        else
            r = 32'(v);
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [SW-1:0] v);
        logic signed [47:0] r;
        if (v > 70'sd140737488355327)
            r = 48'sh7FFFFFFFFFFF;
        else if (v < -70'sd140737488355328)
            r = 48'sh800000000000;
        else
            r = 48'(v);
        return r;
    endfunction

endpackage

[hdl/dhfk_cordic.sv]
module dhfk_cordic
    import dhfk_pkg::*;
(
    input  logic                 clk,
    input  logic                 init,
    input  logic                 step,
    input  logic [4:0]           iter,
    input  logic signed [15:0]   angle,
    output logic signed [CW-1:0] cos_q30,
    output logic signed [CW-1:0] sin_q30
);

    logic signed [CW-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic                 neg_reg, neg_next;
    logic signed [ZW-1:0] z_scaled;
    logic signed [CW-1:0] xs, ys;

    always_comb
    begin
        z_scaled = ZW'(angle) <<< 17;
        xs       = x_reg >>> iter;
        ys       = y_reg >>> iter;
        x_next   = x_reg;
        y_next   = y_reg;
        z_next   = z_reg;
        neg_next = neg_reg;
        if (init)
        begin
            x_next   = CORDIC_K;
            y_next   = '0;
            neg_next = 1'b0;
            z_next   = z_scaled;
            // fold into [-pi/2, pi/2], result negated afterwards
            if (z_scaled > HALFPI_Q30)
            begin
                z_next   = z_scaled - PI_Q30;
                neg_next = 1'b1;
            end
            else if (z_scaled < -HALFPI_Q30)
            begin
                z_next   = z_scaled + PI_Q30;
                neg_next = 1'b1;
            end
        end
        else if (step)
        begin
            if (!z_reg[ZW-1])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_q30(iter);
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_q30(iter);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        neg_reg <= neg_next;
    end

    assign cos_q30 = neg_reg ? -x_reg : x_reg;
    assign sin_q30 = neg_reg ? -y_reg : y_reg;

endmodule

[hdl/dhfk_ctrl.sv]
module dhfk_ctrl
    import dhfk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_valid,
    input  logic       command,
    input  logic [2:0] joint_index,
    input  logic       last_joint,
    input  logic       out_ready,
    output logic       s_ready,
    output logic       out_valid,
    output dhfk_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_MUL,
        ST_COMMIT,
        ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] iter_reg, iter_next;
    logic [3:0] step_reg, step_next;
    logic       last_reg, last_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept, index_ok, slot_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign index_ok  = int'(joint_index) < MAX_JOINTS;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd.start       = accept && index_ok && (command == CMD_ANGLE);
        cmd.geo_write   = accept && index_ok && (command == CMD_GEOMETRY);
        cmd.cordic_step = (state_reg == ST_CORDIC);
        cmd.iter        = iter_reg;
        cmd.mul_issue   = (state_reg == ST_MUL);
        cmd.step        = step_reg;
        cmd.commit      = (state_reg == ST_COMMIT);
        cmd.load_out    = (state_reg == ST_EMIT) && slot_free;
    end

    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        step_next      = step_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = ST_CORDIC;
                    iter_next  = '0;
                    last_next  = last_joint;
                end
            end
            ST_CORDIC:
            begin
                iter_next = iter_reg + 5'd1;
                if (iter_reg == 5'(CORDIC_N - 1))
                begin
                    state_next = ST_MUL;
                    step_next  = STEP_BUILD0;
                end
            end
            ST_MUL:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == STEP_LAST)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iter_reg      <= '0;
            step_reg      <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            step_reg      <= step_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTH
    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> cmd.cordic_step)
        else $error("angle beat did not start the rotation sequence");
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid)
        else $error("loaded result not presented");
    a_commit_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> $past(cmd.mul_issue) && ($past(cmd.step) == STEP_LAST))
        else $error("commit without a full multiply pass");
    a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        !s_ready |-> !(cmd.start || cmd.geo_write))
        else $error("beat taken while busy");
`endif

endmodule

[hdl/dhfk_datapath.sv]
module dhfk_datapath
    import dhfk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dhfk_cmd_t          cmd,
    input  logic [2:0]         joint_index,
    input  logic signed [31:0] joint_offset,
    input  logic signed [31:0] link_length,
    input  logic signed [15:0] link_twist,
    input  logic signed [15:0] joint_angle,
    output logic signed [31:0] rot_out [3][3],
    output logic signed [47:0] pos_out [3]
);

    typedef struct packed {
        logic [1:0] row;
        logic [1:0] col;
        logic       trans;
    } elem_t;

    // element order: nine rotation elements row-major, then three translations;
    // the drain step repeats the last translation
    function automatic elem_t decode(input logic [3:0] step);
        elem_t      d;
        logic [3:0] e;
        e       = step - STEP_ELEM0;
        d.trans = (e >= 4'd9);
        if (d.trans)
        begin
            d.row = (e >= 4'd11) ? 2'd2 : 2'(e - 4'd9);
            d.col = 2'd0;
        end
        else
        begin
            d.row = (e >= 4'd6) ? 2'd2 : ((e >= 4'd3) ? 2'd1 : 2'd0);
            d.col = 2'(e - 4'(3 * d.row));
        end
        return d;
    endfunction

    logic signed [31:0]   offset_table [MAX_JOINTS];
    logic signed [31:0]   length_table [MAX_JOINTS];
    logic signed [15:0]   twist_table  [MAX_JOINTS];
    logic [2:0]           jidx_reg;

    logic signed [31:0]   rot_reg [3][3];
    logic signed [47:0]   pos_reg [3];
    logic signed [31:0]   nr_reg  [3][3];
    logic signed [47:0]   nt_reg  [3];
    logic signed [CW-1:0] rj_reg  [3][3];   // [column][row]
    logic signed [CW-1:0] tj_reg  [2];

    logic signed [CW-1:0] ct, st, ca, sa;
    logic signed [CW-1:0] a_ext, d_ext;
    logic signed [CW-1:0] ma [3];
    logic signed [CW-1:0] mb [3];
    logic signed [PW-1:0] p_reg [3];
    logic [3:0]           step_d_reg;
    logic                 issue_d_reg;
    elem_t                ei, eo;
    logic signed [RW-1:0] r0, r1, r2;
    logic signed [SW-1:0] rsum, tsum;
    logic signed [15:0]   twist_rd;

    assign twist_rd = twist_table[joint_index];
    assign a_ext    = CW'(length_table[jidx_reg]);
    assign d_ext    = CW'(offset_table[jidx_reg]);

    dhfk_cordic u_theta (
        .clk     (clk),
        .init    (cmd.start),
        .step    (cmd.cordic_step),
        .iter    (cmd.iter),
        .angle   (joint_angle),
        .cos_q30 (ct),
        .sin_q30 (st)
    );

    dhfk_cordic u_alpha (
        .clk     (clk),
        .init    (cmd.start),
        .step    (cmd.cordic_step),
        .iter    (cmd.iter),
        .angle   (twist_rd),
        .cos_q30 (ca),
        .sin_q30 (sa)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.geo_write)
        begin
            offset_table[joint_index] <= joint_offset;
            length_table[joint_index] <= link_length;
            twist_table[joint_index]  <= link_twist;
        end
        if (cmd.start)
            jidx_reg <= joint_index;
    end

    // operand select for the three multipliers
    always_comb
    begin
        ei = decode(cmd.step);
        case (cmd.step)
            STEP_BUILD0:
            begin
                ma[0] = ca;    mb[0] = st;
                ma[1] = sa;    mb[1] = st;
                ma[2] = ca;    mb[2] = ct;
            end
            STEP_BUILD1:
            begin
                ma[0] = sa;    mb[0] = ct;
                ma[1] = a_ext; mb[1] = ct;
                ma[2] = a_ext; mb[2] = st;
            end
            STEP_BUBBLE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    ma[k] = '0;
                    mb[k] = '0;
                end
            end
            default:
            begin
                for (int k = 0; k < 3; k++)
                    ma[k] = CW'(rot_reg[ei.row][k]);
                if (ei.trans)
                begin
                    mb[0] = tj_reg[0];
                    mb[1] = tj_reg[1];
                    mb[2] = d_ext;
                end
                else
                begin
                    for (int k = 0; k < 3; k++)
                        mb[k] = rj_reg[ei.col][k];
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
            p_reg[k] <= ma[k] * mb[k];
        step_d_reg <= cmd.step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            issue_d_reg <= 1'b0;
        else
            issue_d_reg <= cmd.mul_issue;
    end

    always_comb
    begin
        eo   = decode(step_d_reg);
        r0   = rnd30(SW'(p_reg[0]));
        r1   = rnd30(SW'(p_reg[1]));
        r2   = rnd30(SW'(p_reg[2]));
        rsum = SW'(p_reg[0]) + SW'(p_reg[1]) + SW'(p_reg[2]);
        tsum = SW'(pos_reg[eo.row]) + SW'(r0) + SW'(r1) + SW'(r2);
    end

    always_ff @(posedge clk)
    begin
        if (issue_d_reg)
        begin
            case (step_d_reg)
                STEP_BUILD0:
                begin
                    rj_reg[0][0] <= ct;
                    rj_reg[1][0] <= CW'(-r0);
                    rj_reg[2][0] <= CW'(r1);
                    rj_reg[0][1] <= st;
                    rj_reg[1][1] <= CW'(r2);
                    rj_reg[0][2] <= '0;
                    rj_reg[1][2] <= sa;
                    rj_reg[2][2] <= ca;
                end
                STEP_BUILD1:
                begin
                    rj_reg[2][1] <= CW'(-r0);
                    tj_reg[0]    <= CW'(r1);
                    tj_reg[1]    <= CW'(r2);
                end
                STEP_BUBBLE:
                begin
                end
                default:
                begin
                    if (eo.trans)
                        nt_reg[eo.row] <= sat48(tsum);
                    else
                        nr_reg[eo.row][eo.col] <= sat32(SW'(rnd30(rsum)));
                end
            endcase
        end
        if (cmd.load_out)
        begin
            rot_out <= rot_reg;
            pos_out <= pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                    rot_reg[r][c] <= (r == c) ? ONE_Q30 : 32'sd0;
                pos_reg[r] <= '0;
            end
        end
        else if (cmd.start && (joint_index == 3'd0))
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                    rot_reg[r][c] <= (r == c) ? ONE_Q30 : 32'sd0;
                pos_reg[r] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            rot_reg <= nr_reg;
            pos_reg <= nt_reg;
        end
    end

endmodule

[hdl/dh_forward_kinematics.sv]
// channel  dir  beat fields
// -------  ---  -----------------------------------------------------------
// s_axis   in   tdata: joint_index, joint_offset, link_length, link_twist,
//               joint_angle; tuser: command; tlast: last_joint
// m_axis   out  tdata: rot_00..rot_22 (row-major), pos_x, pos_y, pos_z
//
// Geometry beat: written to the joint tables as it is taken. Angle beat: an
// init step, 30 CORDIC iterations (both angles in parallel), 16 multiplier
// steps and a commit, plus an emit step for a beat marked last; set by the
// CORDIC loop and the three shared multipliers.
// Reset: accumulator to identity pose; joint tables undefined until written.
// A result waits in its output register while the next beats are taken; a
// second result stalls the block only until the first one leaves.
module dh_forward_kinematics
    import dhfk_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [2:0] joint_index, [34:3] joint_offset, [66:35] link_length,
    // [82:67] link_twist, [98:83] joint_angle, [103:99] zero
    input  logic [103:0] s_tdata,
    // [0] command
    input  logic         s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] rot_00 .. [287:256] rot_22 row-major, [335:288] pos_x,
    // [383:336] pos_y, [431:384] pos_z
    output logic [431:0] m_tdata
);

    dhfk_cmd_t          cmd;
    logic signed [31:0] rot_out [3][3];
    logic signed [47:0] pos_out [3];

    dhfk_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_valid     (s_tvalid),
        .command     (s_tuser),
        .joint_index (s_tdata[2:0]),
        .last_joint  (s_tlast),
        .out_ready   (m_tready),
        .s_ready     (s_tready),
        .out_valid   (m_tvalid),
        .cmd         (cmd)
    );

    dhfk_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .joint_index  (s_tdata[2:0]),
        .joint_offset (s_tdata[34:3]),
        .link_length  (s_tdata[66:35]),
        .link_twist   (s_tdata[82:67]),
        .joint_angle  (s_tdata[98:83]),
        .rot_out      (rot_out),
        .pos_out      (pos_out)
    );

    assign m_tdata = {pos_out[2], pos_out[1], pos_out[0],
                      rot_out[2][2], rot_out[2][1], rot_out[2][0],
                      rot_out[1][2], rot_out[1][1], rot_out[1][0],
                      rot_out[0][2], rot_out[0][1], rot_out[0][0]};

endmodule

[test/dh_forward_kinematics_test.sv]
module dh_forward_kinematics_test;
    import dhfk_pkg::*;

    typedef struct packed {
        logic               command;
        logic [2:0]         joint;
        logic signed [31:0] offset;
        logic signed [31:0] length;
        logic signed [15:0] twist;
        logic signed [15:0] angle;
        logic               last;
    } joint_beat_t;

    typedef struct {
        joint_beat_t beat;
        logic        has_pose;
        logic [431:0] pose;
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic         s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [431:0] m_tdata;

    dh_forward_kinematics u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    localparam longint ROT_HI = 64'sd2147483647;
    localparam longint ROT_LO = -64'sd2147483648;
    localparam longint POS_HI = 64'sd140737488355327;
    localparam longint POS_LO = -64'sd140737488355328;
    localparam int     IDLE_LIMIT = 20000;

    // predictor state
    longint offset_mem [MAX_JOINTS];
    longint length_mem [MAX_JOINTS];
    longint twist_mem  [MAX_JOINTS];
    longint rot_acc [9];
    longint pos_acc [3];

    logic [431:0] pose_queue [$];
    joint_beat_t  send_queue [$];
    int  failures;
    int  idle_cycles;
    bit  quiet_phase;
    bit  stim_done;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint round30(longint p);
        return (p + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // exact rounding for 128-bit sums of products, saturated to the 32-bit range
    function automatic longint round30_wide(logic signed [127:0] p);
        logic signed [127:0] t;
        t = (p + 128'sd536870912) >>> 30;
        if (t > 128'sd2147483647)
            return ROT_HI;
        if (t < -128'sd2147483648)
            return ROT_LO;
        return longint'(t);
    endfunction

    function automatic void atan_entry(int i, output longint v);
        longint tbl [30] = '{
            'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
            'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
            'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
            'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
            'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002};
        v = tbl[i];
    endfunction

    task automatic cordic_sincos(input longint ang, output longint c, output longint s);
        longint z, x, y, nx, at;
        bit flip;
        z = ang * 131072;
        x = 64'sh26DD3B6A;
        y = 0;
        flip = 1'b0;
        if (z > 64'sd1686629713)
        begin
            z -= 64'sd3373259426;
            flip = 1'b1;
        end
        else if (z < -64'sd1686629713)
        begin
            z += 64'sd3373259426;
            flip = 1'b1;
        end
        for (int i = 0; i < 30; i++)
        begin
            atan_entry(i, at);
            if (z >= 0)
            begin
                nx = x - floor_shift(y, i);
                y  = y + floor_shift(x, i);
                z -= at;
            end
            else
            begin
                nx = x + floor_shift(y, i);
                y  = y - floor_shift(x, i);
                z += at;
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic reset_pose();
        for (int k = 0; k < 9; k++)
            rot_acc[k] = (k % 4 == 0) ? (64'sd1 <<< 30) : 0;
        for (int k = 0; k < 3; k++)
            pos_acc[k] = 0;
    endtask

    // returns 1 and the packed pose when the beat emits one
    task automatic chain_step(input joint_beat_t b, output bit emits, output logic [431:0] pose);
        longint ct, st, ca, sa, a;
        longint rj [9];
        longint tj [3];
        longint nr [9];
        longint nt [3];
        logic signed [127:0] acc;
        longint sum;
        int j;
        emits = 1'b0;
        pose = '0;
        j = int'(b.joint);
        if (j >= MAX_JOINTS)
            return;
        if (b.command == CMD_GEOMETRY)
        begin
            offset_mem[j] = longint'(b.offset);
            length_mem[j] = longint'(b.length);
            twist_mem[j]  = longint'(b.twist);
            return;
        end
        if (j == 0)
            reset_pose();
        cordic_sincos(longint'(b.angle), ct, st);
        cordic_sincos(twist_mem[j], ca, sa);
        a = length_mem[j];
        rj = '{ct, -round30(ca * st), round30(sa * st),
               st, round30(ca * ct), -round30(sa * ct),
               0, sa, ca};
        tj = '{round30(a * ct), round30(a * st), offset_mem[j]};
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += 128'(rot_acc[r * 3 + k]) * 128'(rj[k * 3 + c]);
                nr[r * 3 + c] = round30_wide(acc);
            end
            sum = pos_acc[r];
            for (int k = 0; k < 3; k++)
                sum += round30(rot_acc[r * 3 + k] * tj[k]);
            nt[r] = sum > POS_HI ? POS_HI : (sum < POS_LO ? POS_LO : sum);
        end
        rot_acc = nr;
        pos_acc = nt;
        if (!b.last)
            return;
        emits = 1'b1;
        for (int k = 0; k < 9; k++)
            pose[k * 32 +: 32] = rot_acc[k][31:0];
        for (int k = 0; k < 3; k++)
            pose[288 + k * 48 +: 48] = pos_acc[k][47:0];
    endtask

    function automatic joint_beat_t geo_beat(int j, longint d, longint a, longint tw);
        joint_beat_t b;
        b = '0;
        b.command = CMD_GEOMETRY;
        b.joint = 3'(j);
        b.offset = 32'(d);
        b.length = 32'(a);
        b.twist = 16'(tw);
        b.angle = 16'($urandom);
        b.last = 1'($urandom_range(0, 1));
        return b;
    endfunction

    function automatic joint_beat_t angle_beat(int j, longint th, bit last);
        joint_beat_t b;
        b = '0;
        b.command = CMD_ANGLE;
        b.joint = 3'(j);
        b.offset = $urandom;
        b.length = $urandom;
        b.twist = 16'($urandom);
        b.angle = 16'(th);
        b.last = last;
        return b;
    endfunction

    task automatic queue_beat(joint_beat_t b);
        send_queue.push_back(b);
    endtask

    function automatic longint rand_angle();
        case ($urandom_range(0, 4))
            0: return 16'sh7FFF;
            1: return -16'sh8000;
            default: return longint'($signed(16'($urandom)));
        endcase
    endfunction

    function automatic longint rand_q16();
        case ($urandom_range(0, 5))
            0: return 64'sd2147483647;
            1: return -64'sd2147483648;
            2: return longint'($signed($urandom));
            default: return longint'($signed($urandom_range(0, 'h1FFFFF))) - 'h100000;
        endcase
    endfunction

    // send side
    initial
    begin
        joint_beat_t b;
        bit emits;
        logic [431:0] pose;
        stim_row_t rows [$];
        stim_row_t row;
        int n, count;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        failures = 0;
        stim_done = 1'b0;
        reset_pose();
        for (int k = 0; k < MAX_JOINTS; k++)
        begin
            offset_mem[k] = 0;
            length_mem[k] = 0;
            twist_mem[k] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed table: zero geometry, zero angle gives a near-identity pose
        rows.push_back('{geo_beat(0, 0, 0, 0), 1'b0, '0});
        rows.push_back('{angle_beat(0, 0, 1), 1'b0, '0});
        rows.push_back('{geo_beat(1, 64'sd2147483647, 64'sd2147483647, 16'sh7FFF), 1'b0, '0});
        rows.push_back('{geo_beat(2, -64'sd2147483648, -64'sd2147483648, -16'sh8000), 1'b0, '0});
        rows.push_back('{geo_beat(3, 'h10000, 'h20000, 'h0C91), 1'b0, '0});
        rows.push_back('{geo_beat(4, -'h30000, 'h8000, -'h3244), 1'b0, '0});
        rows.push_back('{geo_beat(5, 0, 'h7FFFFFFF, 'h1922), 1'b0, '0});
        rows.push_back('{geo_beat(6, 1, -1, 1), 1'b0, '0});
        rows.push_back('{geo_beat(7, -'h7FFFFFFF, 'h7FFFFFFF, -1), 1'b0, '0});
        rows.push_back('{angle_beat(0, 16'sh7FFF, 0), 1'b0, '0});
        rows.push_back('{angle_beat(1, -16'sh8000, 0), 1'b0, '0});
        rows.push_back('{angle_beat(2, 16'sh3244, 0), 1'b0, '0});
        rows.push_back('{angle_beat(3, -16'sh3244, 0), 1'b0, '0});
        rows.push_back('{angle_beat(4, 16'sh3243, 0), 1'b0, '0});
        rows.push_back('{angle_beat(5, 16'sh6488, 0), 1'b0, '0});
        rows.push_back('{angle_beat(6, -16'sh6488, 0), 1'b0, '0});
        rows.push_back('{angle_beat(7, 16'sh1234, 1), 1'b0, '0});
        // chain not begun at joint 0, emitted pose kept
        rows.push_back('{angle_beat(1, 16'sh7FFF, 1), 1'b0, '0});
        rows.push_back('{angle_beat(7, -16'sh8000, 1), 1'b0, '0});
        // many long links stacked
        for (int r = 0; r < 5; r++)
            rows.push_back('{angle_beat(5, 0, r == 4), 1'b0, '0});
        foreach (rows[i])
        begin
            row = rows[i];
            chain_step(row.beat, emits, pose);
            if (emits)
                pose_queue.push_back(row.has_pose ? row.pose : pose);
            queue_beat(row.beat);
        end

        // random part: mostly well-formed chains
        count = 0;
        while (count < 1550)
        begin
            n = $urandom_range(0, 9);
            if (n < 2)
            begin
                b = geo_beat($urandom_range(0, 7), rand_q16(), rand_q16(), rand_angle());
            end
            else if (n < 8)
            begin
                int len;
                len = $urandom_range(1, 8);
                for (int j = 0; j < len; j++)
                begin
                    b = angle_beat(j, rand_angle(), j == len - 1);
                    chain_step(b, emits, pose);
                    if (emits)
                        pose_queue.push_back(pose);
                    queue_beat(b);
                    count++;
                end
                continue;
            end
            else
                b = angle_beat($urandom_range(0, 7), rand_angle(), 1'($urandom_range(0, 1)));
            chain_step(b, emits, pose);
            if (emits)
                pose_queue.push_back(pose);
            queue_beat(b);
            count++;
        end

        while (send_queue.size() > 0)
        begin
            @(posedge clk);
            if (s_tvalid && s_tready)
            begin
                void'(send_queue.pop_front());
            end
            if (send_queue.size() == 0 || (s_tvalid && !s_tready))
            begin
                if (send_queue.size() == 0)
                    s_tvalid <= 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 99) < 20)
                s_tvalid <= 1'b0;
            else
            begin
                b = send_queue[0];
                s_tvalid <= 1'b1;
                s_tdata <= {5'b0, b.angle, b.twist, b.length, b.offset, b.joint};
                s_tuser <= b.command;
                s_tlast <= b.last;
            end
        end
        stim_done = 1'b1;
    end

    // receive side: every pose beat is checked against the expected queue
    initial
    begin
        logic [431:0] exp_pose;
        m_tready = 1'b0;
        quiet_phase = 1'b0;
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            quiet_phase = ($time / 12) % 20000 > 14000;
            if (m_tvalid && m_tready)
            begin
                if (pose_queue.size() == 0)
                begin
                    $display("%0t: unexpected pose beat %h", $time, m_tdata);
                    failures++;
                end
                else
                begin
                    exp_pose = pose_queue.pop_front();
                    for (int k = 0; k < 12; k++)
                    begin
                        int lo, w;
                        lo = k < 9 ? k * 32 : 288 + (k - 9) * 48;
                        w = k < 9 ? 32 : 48;
                        if ((m_tdata >> lo) % (64'd1 << w) != (exp_pose >> lo) % (64'd1 << w))
                        begin
                            $display("%0t: field %0d expected %h actual %h", $time, k,
                                (exp_pose >> lo) % (64'd1 << w),
                                (m_tdata >> lo) % (64'd1 << w));
                            failures++;
                        end
                    end
                end
            end
            m_tready <= quiet_phase || $urandom_range(0, 99) >= 20;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("dh_forward_kinematics_test NOT OK");
                $finish;
            end
            if (stim_done && pose_queue.size() == 0)
            begin
                m_tready <= 1'b1;
                repeat (100)
                begin
                    @(posedge clk);
                    if (m_tvalid && m_tready)
                    begin
                        $display("%0t: unexpected pose beat %h", $time, m_tdata);
                        failures++;
                    end
                end
                if (failures == 0)
                    $display("dh_forward_kinematics_test OK");
                else
                    $display("dh_forward_kinematics_test NOT OK");
                $finish;
            end
        end
    end

endmodule
